@@ rtl/core/key_gesture_event_queue_defines.svh @@
// Assertion macros shared by the key gesture event queue RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef KEY_GESTURE_EVENT_QUEUE_DEFINES_SVH
`define KEY_GESTURE_EVENT_QUEUE_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define KGEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define KGEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kgeq_pkg.sv @@
// Package of the key gesture event queue: sizes, codes, payload and state types.
// Used by kgeq_key_step and key_gesture_event_queue; depends on nothing.
package kgeq_pkg;

    localparam int KEYS        = 8;
    localparam int QUEUE_SLOTS = 8;
    localparam int QUEUE_DEPTH = KEYS * QUEUE_SLOTS;
    localparam int KEY_W       = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    localparam logic [5:0] EV_DOWN   = 6'h01;
    localparam logic [5:0] EV_UP     = 6'h02;
    localparam logic [5:0] EV_CLICK  = 6'h04;
    localparam logic [5:0] EV_DOUBLE = 6'h08;
    localparam logic [5:0] EV_LONG   = 6'h10;
    localparam logic [5:0] EV_REPEAT = 6'h20;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2
    } kgeq_cmd_t;

    typedef enum logic [2:0] {
        REG_DEBOUNCE_TICKS   = 3'd0,
        REG_LONG_TICKS       = 3'd1,
        REG_DOUBLE_TICKS     = 3'd2,
        REG_REPEAT_TICKS     = 3'd3,
        REG_PRESS_LEVEL_MASK = 3'd4,
        REG_FEATURE_ENABLE   = 3'd5,
        REG_KEY_ENABLE_MASK  = 3'd6
    } kgeq_reg_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_PRESSED  = 3'd1,
        MODE_RELEASED = 3'd2,
        MODE_DOUBLE   = 3'd3,
        MODE_LONG     = 3'd4
    } kgeq_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_POP,
        ST_POP_OUT,
        ST_CLEAR
    } kgeq_fsm_t;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] key_index;
        logic [7:0] pin_levels;
    } kgeq_request_t;

    typedef struct packed {
        logic [5:0] event_flags;
        logic       queue_was_empty;
    } kgeq_result_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_ticks;
        logic [15:0] double_ticks;
        logic [15:0] repeat_ticks;
        logic [2:0]  feature_enable;
    } kgeq_timing_t;

    typedef struct packed {
        logic [15:0]       debounce_count;
        logic              prev_pressed;
        logic              cur_pressed;
        kgeq_mode_t        mode;
        logic [15:0]       hold_timer;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } kgeq_key_state_t;

    localparam kgeq_key_state_t KEY_STATE_RESET = kgeq_key_state_t'('0);

    function automatic logic key_bit(input logic [7:0] mask, input int unsigned k);
        logic [2:0] sel;
        sel = k[2:0];
        return (k < 8) ? mask[sel] : 1'b0;
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
        return (int'(p) + 1 >= QUEUE_SLOTS) ? '0 : p + SLOT_W'(1);
    endfunction

    function automatic logic [QA_W-1:0] queue_addr(input logic [KEY_W-1:0] k,
                                                   input logic [SLOT_W-1:0] s);
        return QA_W'(int'(k) * QUEUE_SLOTS + int'(s));
    endfunction

endpackage

@@ rtl/core/key_gesture_event_queue.sv @@
// Top level of the key gesture event queue: command sequencer, key state memory and
// event FIFO memory. Depends on kgeq_pkg, kgeq_key_step and the assertion macros.

// A command transaction is taken when start is high and busy is low. A tick visits the
// keys one per cycle through the key state memory and holds busy high until it has
// updated the last key. A pop reads the key state and then the event FIFO memory; its
// result is registered and shown with done for one cycle (from ST_POP_OUT, from ST_POP
// when the FIFO is empty, or straight from idle when the key index is out of range), and
// a new command may be taken in that same cycle. A clear sets the key's head to its tail.
// The receiver cannot stall: each result must be captured in the cycle done is high.
// Configuration writes take effect at once and are meant for when busy is low.
`include "key_gesture_event_queue_defines.svh"

module key_gesture_event_queue
    import kgeq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  kgeq_request_t request,
    output logic          busy,
    output logic          done,
    output kgeq_result_t  result,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    logic [15:0] debounce_ticks_reg;
    logic [15:0] long_ticks_reg;
    logic [15:0] double_ticks_reg;
    logic [15:0] repeat_ticks_reg;
    logic [7:0]  active_mask_reg;
    logic [2:0]  feature_enable_reg;
    logic [7:0]  key_enable_mask_reg;
    logic [7:0]  enable_rising;

    kgeq_fsm_t       state_reg, state_next;
    logic [KEY_W-1:0] exec_key_reg, exec_key_next;
    logic [KEY_W-1:0] op_key_reg, op_key_next;
    logic [7:0]       pins_reg, pins_next;
    logic             done_reg, done_next;
    kgeq_result_t     result_reg, result_next;

    kgeq_key_state_t state_mem [KEYS];
    kgeq_key_state_t state_rd_reg;
    logic            state_rd_valid_reg;
    logic [KEYS-1:0] key_valid_reg;
    logic [5:0]      queue_mem [QUEUE_DEPTH];
    logic [5:0]      q_rd_reg;

    logic [KEY_W-1:0] st_raddr;
    logic [KEY_W-1:0] st_waddr;
    logic             st_we;
    kgeq_key_state_t  st_wdata;
    logic [QA_W-1:0]  q_raddr;
    logic [QA_W-1:0]  q_waddr;
    logic             q_we;
    logic [5:0]       q_wdata;

    kgeq_key_state_t   cur_key;
    kgeq_key_state_t   step_key;
    logic [5:0]        step_flags;
    kgeq_timing_t      timing;
    logic [SLOT_W-1:0] push_slot;
    logic              req_in_range;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign timing = '{debounce_ticks: debounce_ticks_reg,
                      long_ticks:     long_ticks_reg,
                      double_ticks:   double_ticks_reg,
                      repeat_ticks:   repeat_ticks_reg,
                      feature_enable: feature_enable_reg};

    assign enable_rising = cfg_data[7:0] & ~key_enable_mask_reg;
    assign cur_key       = state_rd_valid_reg ? state_rd_reg : KEY_STATE_RESET;
    assign push_slot     = next_slot(cur_key.tail);
    assign req_in_range  = (int'(request.key_index) < KEYS);

    kgeq_key_step u_key_step (
        .key_in       (cur_key),
        .pin_level    (key_bit(pins_reg, int'(exec_key_reg))),
        .active_level (key_bit(active_mask_reg, int'(exec_key_reg))),
        .timing       (timing),
        .key_out      (step_key),
        .flags        (step_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg  <= 16'd20;
            long_ticks_reg      <= 16'd1000;
            double_ticks_reg    <= 16'd300;
            repeat_ticks_reg    <= 16'd200;
            active_mask_reg     <= 8'd0;
            feature_enable_reg  <= 3'd7;
            key_enable_mask_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg  <= cfg_data;
                REG_LONG_TICKS:       long_ticks_reg      <= cfg_data;
                REG_DOUBLE_TICKS:     double_ticks_reg    <= cfg_data;
                REG_REPEAT_TICKS:     repeat_ticks_reg    <= cfg_data;
                REG_PRESS_LEVEL_MASK: active_mask_reg     <= cfg_data[7:0];
                REG_FEATURE_ENABLE:   feature_enable_reg  <= cfg_data[2:0];
                REG_KEY_ENABLE_MASK:  key_enable_mask_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // An entry whose valid bit is clear reads as the reset state of its key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg      <= '0;
            state_rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_rd_valid_reg <= key_valid_reg[st_raddr];
            if (cfg_we && (cfg_index == REG_KEY_ENABLE_MASK))
            begin
                for (int k = 0; k < KEYS; k++)
                begin
                    if (key_bit(enable_rising, k))
                    begin
                        key_valid_reg[k] <= 1'b0;
                    end
                end
            end
            else if (st_we)
            begin
                key_valid_reg[st_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            state_mem[st_waddr] <= st_wdata;
        end
        state_rd_reg <= state_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= queue_mem[q_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exec_key_reg <= exec_key_next;
        op_key_reg   <= op_key_next;
        pins_reg     <= pins_next;
        result_reg   <= result_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        exec_key_next = exec_key_reg;
        op_key_next   = op_key_reg;
        pins_next     = pins_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        st_raddr      = op_key_reg;
        st_waddr      = op_key_reg;
        st_we         = 1'b0;
        st_wdata      = step_key;
        q_raddr       = queue_addr(op_key_reg, cur_key.head);
        q_waddr       = queue_addr(exec_key_reg, cur_key.tail);
        q_we          = 1'b0;
        q_wdata       = step_flags;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (request.command)
                        CMD_TICK:
                        begin
                            exec_key_next = '0;
                            pins_next     = request.pin_levels;
                            st_raddr      = '0;
                            state_next    = ST_TICK;
                        end
                        CMD_POP:
                        begin
                            if (req_in_range)
                            begin
                                op_key_next = KEY_W'(request.key_index);
                                st_raddr    = KEY_W'(request.key_index);
                                state_next  = ST_POP;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{event_flags: '0, queue_was_empty: 1'b1};
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (req_in_range)
                            begin
                                op_key_next = KEY_W'(request.key_index);
                                st_raddr    = KEY_W'(request.key_index);
                                state_next  = ST_CLEAR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                st_waddr = exec_key_reg;
                if (key_bit(key_enable_mask_reg, int'(exec_key_reg)))
                begin
                    st_we = 1'b1;
                    if ((step_flags != 6'd0) && (push_slot != cur_key.head))
                    begin
                        q_we          = 1'b1;
                        st_wdata.tail = push_slot;
                    end
                end
                if (exec_key_reg == KEY_W'(KEYS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    exec_key_next = exec_key_reg + KEY_W'(1);
                    st_raddr      = exec_key_reg + KEY_W'(1);
                end
            end
            ST_POP:
            begin
                st_wdata = cur_key;
                if (cur_key.head != cur_key.tail)
                begin
                    st_we         = 1'b1;
                    st_wdata.head = next_slot(cur_key.head);
                    state_next    = ST_POP_OUT;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{event_flags: '0, queue_was_empty: 1'b1};
                    state_next  = ST_IDLE;
                end
            end
            ST_POP_OUT:
            begin
                done_next   = 1'b1;
                result_next = '{event_flags: q_rd_reg, queue_was_empty: 1'b0};
                state_next  = ST_IDLE;
            end
            ST_CLEAR:
            begin
                st_we         = 1'b1;
                st_wdata      = cur_key;
                st_wdata.head = cur_key.tail;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Only nonzero flag sets are queued, so a popped transaction is empty exactly when
    // its flags are zero.
    `KGEQ_ASSERT_SAME(a_empty_matches_flags, done_reg,
        result_reg.queue_was_empty == (result_reg.event_flags == 6'd0),
        "pop result empty bit disagrees with its flags")
    `KGEQ_ASSERT_NEXT(a_tick_goes_busy, start && !busy && (request.command == CMD_TICK),
        busy, "accepted tick did not raise busy")
    `KGEQ_ASSERT_SAME(a_push_only_in_tick, q_we, (state_reg == ST_TICK) && st_we,
        "event FIFO written outside a tick key update")
    `KGEQ_ASSERT_NEXT(a_pop_out_delivers, state_reg == ST_POP_OUT,
        done_reg && !result_reg.queue_was_empty, "non-empty pop did not deliver a result")

endmodule

@@ rtl/core/kgeq_key_step.sv @@
// One tick of one key: hold timer, debounce sampling, edge flags and gesture machine.
// Combinational; depends on kgeq_pkg. The queue pointers pass through unchanged.
module kgeq_key_step
    import kgeq_pkg::*;
(
    input  kgeq_key_state_t key_in,
    input  logic            pin_level,
    input  logic            active_level,
    input  kgeq_timing_t    timing,
    output kgeq_key_state_t key_out,
    output logic [5:0]      flags
);

    logic        pressed;
    logic [15:0] hold;
    logic [16:0] cnt;

    always_comb
    begin
        key_out = key_in;
        flags   = '0;
        pressed = (pin_level == active_level);
        hold    = key_in.hold_timer;
        if (hold != 16'd0)
        begin
            hold = hold - 16'd1;
        end
        cnt = {1'b0, key_in.debounce_count} + 17'd1;
        key_out.hold_timer = hold;
        if (cnt < {1'b0, timing.debounce_ticks})
        begin
            key_out.debounce_count = cnt[15:0];
        end
        else
        begin
            key_out.debounce_count = '0;
            key_out.prev_pressed   = key_in.cur_pressed;
            key_out.cur_pressed    = pressed;
            if (!key_in.cur_pressed && pressed)
            begin
                flags = flags | EV_DOWN;
            end
            else if (key_in.cur_pressed && !pressed)
            begin
                flags = flags | EV_UP;
            end
            case (key_in.mode)
                MODE_IDLE:
                begin
                    if (pressed)
                    begin
                        key_out.hold_timer = timing.long_ticks;
                        key_out.mode       = MODE_PRESSED;
                    end
                end
                MODE_PRESSED:
                begin
                    if (!pressed)
                    begin
                        if (timing.feature_enable[0])
                        begin
                            key_out.hold_timer = timing.double_ticks;
                            key_out.mode       = MODE_RELEASED;
                        end
                        else
                        begin
                            flags        = flags | EV_CLICK;
                            key_out.mode = MODE_IDLE;
                        end
                    end
                    else if (hold == 16'd0)
                    begin
                        key_out.hold_timer = timing.repeat_ticks;
                        if (timing.feature_enable[1])
                        begin
                            flags = flags | EV_LONG;
                        end
                        key_out.mode = MODE_LONG;
                    end
                end
                MODE_RELEASED:
                begin
                    if (pressed)
                    begin
                        if (timing.feature_enable[0])
                        begin
                            flags = flags | EV_DOUBLE;
                        end
                        key_out.hold_timer = '0;
                        key_out.mode       = MODE_DOUBLE;
                    end
                    else if (hold == 16'd0)
                    begin
                        flags        = flags | EV_CLICK;
                        key_out.mode = MODE_IDLE;
                    end
                end
                MODE_DOUBLE:
                begin
                    if (!pressed)
                    begin
                        key_out.mode = MODE_IDLE;
                    end
                end
                MODE_LONG:
                begin
                    if (!pressed)
                    begin
                        key_out.mode = MODE_IDLE;
                    end
                    else if (hold == 16'd0)
                    begin
                        key_out.hold_timer = timing.repeat_ticks;
                        if (timing.feature_enable[2])
                        begin
                            flags = flags | EV_REPEAT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ tb/kgeq_event_checker.sv @@
// Checker of the key gesture event queue: watches the command, result and register ports,
// keeps its own copy of every key's debounce, gesture and FIFO state, and scores each pop.
// Depends on kgeq_pkg for the payload types, codes and sizes.
module kgeq_event_checker
    import kgeq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  kgeq_request_t request,
    input  logic          busy,
    input  logic          done,
    input  kgeq_result_t  result,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output int            mismatches,
    output int            outstanding
);

    logic [15:0]  debounce_ticks_q;
    logic [15:0]  long_ticks_q;
    logic [15:0]  double_ticks_q;
    logic [15:0]  repeat_ticks_q;
    logic [7:0]   active_level_q;
    logic [2:0]   features_q;
    logic [7:0]   key_enable_q;

    logic [15:0]  sample_count [KEYS];
    logic         was_pressed  [KEYS];
    logic         is_pressed   [KEYS];
    kgeq_mode_t   gesture      [KEYS];
    logic [15:0]  hold_count   [KEYS];
    logic [5:0]   fifo_mem     [QUEUE_DEPTH];
    int           rd_ptr       [KEYS];
    int           wr_ptr       [KEYS];

    kgeq_result_t pending_pops [$];

    function automatic int wrap_slot(input int p);
        return (p + 1 >= QUEUE_SLOTS) ? 0 : p + 1;
    endfunction

    function automatic void clear_key(input int k);
        sample_count[k] = '0;
        was_pressed[k]  = 1'b0;
        is_pressed[k]   = 1'b0;
        gesture[k]      = MODE_IDLE;
        hold_count[k]   = '0;
        rd_ptr[k]       = 0;
        wr_ptr[k]       = 0;
    endfunction

    function automatic void reset_model();
        int i;
        debounce_ticks_q = 16'd20;
        long_ticks_q     = 16'd1000;
        double_ticks_q   = 16'd300;
        repeat_ticks_q   = 16'd200;
        active_level_q   = 8'h00;
        features_q       = 3'd7;
        key_enable_q     = 8'h00;
        for (i = 0; i < KEYS; i++)
            clear_key(i);
        for (i = 0; i < QUEUE_DEPTH; i++)
            fifo_mem[i] = '0;
    endfunction

    function automatic void push_events(input int k, input logic [5:0] flags);
        int nt;
        nt = wrap_slot(wr_ptr[k]);
        if (nt == rd_ptr[k])
            return;
        fifo_mem[k * QUEUE_SLOTS + wr_ptr[k]] = flags;
        wr_ptr[k] = nt;
    endfunction

    function automatic void advance_key(input int k, input logic [7:0] pins);
        logic [5:0] flags;
        int         cnt;
        logic       pressed;
        flags = '0;
        if (hold_count[k] != 0)
            hold_count[k] = hold_count[k] - 16'd1;
        cnt = int'(sample_count[k]) + 1;
        if (cnt < int'(debounce_ticks_q)) begin
            sample_count[k] = 16'(cnt);
            return;
        end
        sample_count[k] = '0;
        was_pressed[k]  = is_pressed[k];
        pressed         = (pins[k] == active_level_q[k]);
        is_pressed[k]   = pressed;
        if (!was_pressed[k] && pressed)
            flags |= EV_DOWN;
        else if (was_pressed[k] && !pressed)
            flags |= EV_UP;
        case (gesture[k])
            MODE_IDLE:
                if (pressed)
                begin
                    hold_count[k] = long_ticks_q;
                    gesture[k]    = MODE_PRESSED;
                end
            MODE_PRESSED:
                if (!pressed)
                begin
                    if (features_q[0])
                    begin
                        hold_count[k] = double_ticks_q;
                        gesture[k]    = MODE_RELEASED;
                    end
                    else
                    begin
                        flags |= EV_CLICK;
                        gesture[k] = MODE_IDLE;
                    end
                end
                else if (hold_count[k] == 0)
                begin
                    hold_count[k] = repeat_ticks_q;
                    if (features_q[1])
                        flags |= EV_LONG;
                    gesture[k] = MODE_LONG;
                end
            MODE_RELEASED:
                if (pressed)
                begin
                    if (features_q[0])
                        flags |= EV_DOUBLE;
                    hold_count[k] = '0;
                    gesture[k]    = MODE_DOUBLE;
                end
                else if (hold_count[k] == 0)
                begin
                    flags |= EV_CLICK;
                    gesture[k] = MODE_IDLE;
                end
            MODE_DOUBLE:
                if (!pressed)
                    gesture[k] = MODE_IDLE;
            MODE_LONG:
                if (!pressed)
                    gesture[k] = MODE_IDLE;
                else if (hold_count[k] == 0)
                begin
                    hold_count[k] = repeat_ticks_q;
                    if (features_q[2])
                        flags |= EV_REPEAT;
                end
            default: ;
        endcase
        if (flags != 0)
            push_events(k, flags);
    endfunction

    function automatic void write_register(input logic [2:0] idx, input logic [15:0] data);
        logic [7:0] rising;
        int         i;
        case (idx)
            REG_DEBOUNCE_TICKS:   debounce_ticks_q = data;
            REG_LONG_TICKS:       long_ticks_q     = data;
            REG_DOUBLE_TICKS:     double_ticks_q   = data;
            REG_REPEAT_TICKS:     repeat_ticks_q   = data;
            REG_PRESS_LEVEL_MASK: active_level_q   = data[7:0];
            REG_FEATURE_ENABLE:   features_q       = data[2:0];
            REG_KEY_ENABLE_MASK:
            begin
                rising       = data[7:0] & ~key_enable_q;
                key_enable_q = data[7:0];
                for (i = 0; i < KEYS; i++)
                    if (rising[i])
                        clear_key(i);
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_command(input kgeq_request_t req);
        kgeq_result_t r;
        int           k;
        int           i;
        k = int'(req.key_index);
        case (req.command)
            CMD_TICK:
                for (i = 0; i < KEYS; i++)
                    if (key_enable_q[i])
                        advance_key(i, req.pin_levels);
            CMD_POP:
            begin
                r.event_flags     = '0;
                r.queue_was_empty = 1'b1;
                if (k < KEYS && rd_ptr[k] != wr_ptr[k])
                begin
                    r.event_flags     = fifo_mem[k * QUEUE_SLOTS + rd_ptr[k]];
                    r.queue_was_empty = 1'b0;
                    rd_ptr[k]         = wrap_slot(rd_ptr[k]);
                end
                pending_pops.push_back(r);
            end
            CMD_CLEAR:
                if (k < KEYS)
                    rd_ptr[k] = wr_ptr[k];
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s expected 0x%0h actual 0x%0h", what, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kgeq_result_t want;
        if (!rst_n)
        begin
            reset_model();
            pending_pops.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_pops.size() == 0)
                    note_failure("result with no pop pending, event_flags", 0,
                                 int'(result.event_flags));
                else
                begin
                    want = pending_pops.pop_front();
                    if (result.event_flags !== want.event_flags)
                        note_failure("event_flags", int'(want.event_flags),
                                     int'(result.event_flags));
                    if (result.queue_was_empty !== want.queue_was_empty)
                        note_failure("queue_was_empty", int'(want.queue_was_empty),
                                     int'(result.queue_was_empty));
                end
            end
            if (cfg_we)
                write_register(cfg_index, cfg_data);
            if (start && !busy)
                apply_command(request);
            outstanding = pending_pops.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the key gesture event queue regression: clock, reset, register setup per phase and
// command stimulus, directed first and then random; the verdict comes from the checker.
// Depends on kgeq_pkg, key_gesture_event_queue and kgeq_event_checker.
module tb;
    import kgeq_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic [2:0] REG_UNUSED    = 3'd7;
    localparam int         RANDOM_PHASES = 8;
    localparam int         CYCLE_LIMIT   = 400000;

    logic          clk;
    logic          rst_n;
    logic          start;
    kgeq_request_t request;
    logic          busy;
    logic          done;
    kgeq_result_t  result;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [15:0]   cfg_data;

    int            mismatches;
    int            outstanding;
    int            cycles;
    logic [7:0]    held_pins;
    bit            gaps_on;

    key_gesture_event_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kgeq_event_checker event_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("key_gesture_event_queue regression: fail");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_command(input logic [1:0] cmd, input logic [2:0] idx,
                                input logic [7:0] pins);
        start   <= 1'b1;
        request <= '{command: cmd, key_index: idx, pin_levels: pins};
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Ticks and clears give no result, so a tick may still be running when the last
    // pop has been scored.
    task automatic settle();
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (KEYS + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pad8(input logic [7:0] v);
        return {8'($urandom), v};
    endfunction

    task automatic configure_phase(input int p);
        case (p)
            0:
            begin
                write_reg(REG_DEBOUNCE_TICKS, 16'd0);
                write_reg(REG_LONG_TICKS, 16'd3);
                write_reg(REG_DOUBLE_TICKS, 16'd3);
                write_reg(REG_REPEAT_TICKS, 16'd2);
                write_reg(REG_PRESS_LEVEL_MASK, pad8(8'($urandom)));
                write_reg(REG_FEATURE_ENABLE, 16'd7);
                write_reg(REG_KEY_ENABLE_MASK, 16'h0000);
                write_reg(REG_KEY_ENABLE_MASK, pad8(8'hFF));
            end
            1:
            begin
                write_reg(REG_DEBOUNCE_TICKS, 16'd1);
                write_reg(REG_LONG_TICKS, 16'd1);
                write_reg(REG_DOUBLE_TICKS, 16'd1);
                write_reg(REG_REPEAT_TICKS, 16'd1);
                write_reg(REG_PRESS_LEVEL_MASK, pad8(8'h00));
                write_reg(REG_FEATURE_ENABLE, pad8(8'h00));
                write_reg(REG_KEY_ENABLE_MASK, pad8(8'($urandom)));
            end
            2:
            begin
                write_reg(REG_DEBOUNCE_TICKS, 16'd3);
                write_reg(REG_LONG_TICKS, 16'd0);
                write_reg(REG_DOUBLE_TICKS, 16'd0);
                write_reg(REG_REPEAT_TICKS, 16'd0);
                write_reg(REG_PRESS_LEVEL_MASK, pad8(8'hFF));
                write_reg(REG_FEATURE_ENABLE, 16'($urandom_range(0, 65535)));
                write_reg(REG_KEY_ENABLE_MASK, pad8(8'hFF));
            end
            3:
            begin
                write_reg(REG_DEBOUNCE_TICKS, 16'hFFFF);
                write_reg(REG_LONG_TICKS, 16'hFFFF);
                write_reg(REG_DOUBLE_TICKS, 16'hFFFF);
                write_reg(REG_REPEAT_TICKS, 16'hFFFF);
                write_reg(REG_PRESS_LEVEL_MASK, 16'hFFFF);
                write_reg(REG_FEATURE_ENABLE, 16'hFFFF);
                write_reg(REG_KEY_ENABLE_MASK, 16'hFFFF);
            end
            4:
            begin
                write_reg(REG_DEBOUNCE_TICKS, 16'd2);
                write_reg(REG_LONG_TICKS, 16'hFFFF);
                write_reg(REG_DOUBLE_TICKS, 16'd5);
                write_reg(REG_REPEAT_TICKS, 16'hFFFF);
                write_reg(REG_FEATURE_ENABLE, 16'd2);
                write_reg(REG_KEY_ENABLE_MASK, pad8(8'h55));
            end
            default:
            begin
                write_reg(REG_DEBOUNCE_TICKS, 16'($urandom_range(0, 4)));
                write_reg(REG_LONG_TICKS, 16'($urandom_range(0, 24)));
                write_reg(REG_DOUBLE_TICKS, 16'($urandom_range(0, 12)));
                write_reg(REG_REPEAT_TICKS, 16'($urandom_range(0, 8)));
                write_reg(REG_PRESS_LEVEL_MASK, pad8(8'($urandom)));
                write_reg(REG_FEATURE_ENABLE, pad8(8'($urandom)));
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_KEY_ENABLE_MASK, 16'h0000);
                write_reg(REG_KEY_ENABLE_MASK, pad8(8'($urandom)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    // Mostly ticks whose pins follow held buttons, with pops to read the events back.
    task automatic random_item();
        int         r;
        int         b;
        logic [2:0] idx;
        logic [7:0] pins;
        r   = $urandom_range(0, 99);
        idx = 3'($urandom_range(0, 7));
        if (r < 62)
        begin
            for (b = 0; b < 8; b++)
                if ($urandom_range(0, 7) == 0)
                    held_pins[b] = ~held_pins[b];
            pins = ($urandom_range(0, 19) == 0) ? 8'($urandom) : held_pins;
            send_command(CMD_TICK, idx, pins);
        end
        else if (r < 92)
            send_command(CMD_POP, idx, 8'($urandom));
        else if (r < 97)
            send_command(CMD_CLEAR, idx, 8'($urandom));
        else
            send_command(CMD_UNUSED, idx, 8'($urandom));
        if (gaps_on && $urandom_range(0, 4) == 0)
            pause($urandom_range(1, 12));
    endtask

    initial
    begin
        int p;
        int n;
        int count;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        held_pins = 8'hF0;
        gaps_on   = 1'b1;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        settle();

        // Keys 0-3 are pressed at pin level 1, keys 4-7 at level 0.
        write_reg(REG_DEBOUNCE_TICKS, 16'd0);
        write_reg(REG_LONG_TICKS, 16'd2);
        write_reg(REG_DOUBLE_TICKS, 16'd2);
        write_reg(REG_REPEAT_TICKS, 16'd1);
        write_reg(REG_PRESS_LEVEL_MASK, 16'h000F);
        write_reg(REG_FEATURE_ENABLE, 16'd7);
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        write_reg(REG_KEY_ENABLE_MASK, 16'h00FF);
        cfg_we <= 1'b0;

        send_command(CMD_POP, 3'd0, 8'h00);
        send_command(CMD_TICK, 3'd0, 8'hF0);
        repeat (4) send_command(CMD_TICK, 3'd0, 8'hF1);
        send_command(CMD_TICK, 3'd0, 8'hF0);
        send_command(CMD_TICK, 3'd1, 8'hF2);
        send_command(CMD_TICK, 3'd1, 8'hF0);
        send_command(CMD_TICK, 3'd2, 8'hF2);
        send_command(CMD_TICK, 3'd2, 8'hF0);
        // Toggling every key overruns key 0's FIFO so that later sets are dropped.
        repeat (3)
        begin
            send_command(CMD_TICK, 3'd7, 8'h0F);
            send_command(CMD_TICK, 3'd7, 8'hF0);
        end
        send_command(CMD_POP, 3'd0, 8'hFF);
        send_command(CMD_POP, 3'd1, 8'h00);
        send_command(CMD_CLEAR, 3'd3, 8'h00);
        send_command(CMD_POP, 3'd3, 8'h00);
        send_command(CMD_UNUSED, 3'd5, 8'hFF);
        send_command(CMD_TICK, 3'd0, 8'h00);
        send_command(CMD_TICK, 3'd0, 8'hFF);
        send_command(CMD_POP, 3'd4, 8'h00);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            configure_phase(p);
            held_pins = 8'($urandom);
            gaps_on   = (p != RANDOM_PHASES - 1);
            count     = (p == 3) ? 60 : 205;
            for (n = 0; n < count; n++)
                random_item();
        end
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("key_gesture_event_queue regression: pass");
        else
            $display("key_gesture_event_queue regression: fail");
        $finish;
    end

endmodule

@@ key_gesture_event_queue.f @@
+incdir+rtl/core
rtl/core/kgeq_pkg.sv
rtl/core/kgeq_key_step.sv
rtl/core/key_gesture_event_queue.sv
tb/kgeq_event_checker.sv
tb/tb.sv
